FILE: design/dtr_pkg.sv
// Shared types and codes for the download request tracker.
package dtr_pkg;

   // Operation codes on req_func
   typedef enum logic [2:0] {
      FUNC_ADD      = 3'd0,
      FUNC_ACCEPT   = 3'd1,
      FUNC_BATCH    = 3'd2,
      FUNC_NACK     = 3'd3,
      FUNC_WITHDRAW = 3'd4
   } func_type;

   // Result status codes
   typedef enum logic [2:0] {
      STAT_LINE      = 3'd0,
      STAT_WITHDRAWN = 3'd1,
      STAT_ACCEPTED  = 3'd2,
      STAT_NOT_REQ   = 3'd3,
      STAT_DUP       = 3'd4,
      STAT_EMPTY     = 3'd5,
      STAT_FULL      = 3'd6,
      STAT_ADDED     = 3'd7
   } status_type;

   // Configuration register indexes
   typedef enum logic [1:0] {
      CSR_DEADLINE = 2'd0,
      CSR_BATCH    = 2'd1,
      CSR_BACKOFF  = 2'd2,
      CSR_CREDIT   = 2'd3
   } csr_index_type;

   // Sequencer states
   typedef enum logic [4:0] {
      ST_IDLE, ST_A_SCAN, ST_A_DEC, ST_A_SHIFT, ST_A_PUT,
      ST_C_ID, ST_C_KEY, ST_C_END, ST_C_CLR,
      ST_B_CHK, ST_B_STALE, ST_B_CNT, ST_B_CMP, ST_B_NEW, ST_B_FIN,
      ST_N_SCAN,
      ST_W_CNT, ST_W_UPD, ST_W_OUT, ST_W_SHIFT,
      ST_DONE
   } state_type;

   localparam int HEIGHT_W = 40;
   localparam int KEY_W    = 64;
   localparam int TICK_W   = 32;
   localparam int CNT_W    = 7;
   localparam logic [CNT_W-1:0] MAX_RESULTS = 7'd64;

   // One table entry as held in the entry memory
   typedef struct packed {
      logic [HEIGHT_W-1:0] height;
      logic [KEY_W-1:0]    key;
      logic [KEY_W-1:0]    req_id;
      logic [TICK_W-1:0]   req_time;
      logic                ready;
      logic                matched;
      logic                requested;
   } entry_type;

endpackage

FILE: design/dtr_entry_ram.sv
// Entry memory: one write port, one registered read port.
module dtr_entry_ram
   import dtr_pkg::*;
#(
   parameter int DEPTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  entry_type                wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output entry_type                rd_data
);

   entry_type mem [DEPTH];
   entry_type rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // read port, registered
   always_ff @(posedge clock) begin
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

FILE: design/download_request_tracker.sv
// Top level: download request tracker with table sequencer and result beats.
// Each table step is a memory read, then evaluate and write back.
// Throughput: one item at a time; busy stays high until the last beat is out.
// Reset restores register defaults and clears fill count, ready count and nack time, not memory.
// Beats leave through a one-deep hold register; no stall.
module download_request_tracker
   import dtr_pkg::*;
#(
   parameter int TABLE_DEPTH = 64,
   parameter int MAX_BATCH   = 64
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  logic [2:0]          req_func,
   input  logic [HEIGHT_W-1:0] req_block_height,
   input  logic [KEY_W-1:0]    req_match_key,
   input  logic [KEY_W-1:0]    req_request_id,
   input  logic [TICK_W-1:0]   req_now_ticks,
   input  logic [7:0]          req_active_peers,
   input  logic                req_last_in_packet,
   output logic                rsp_strobe,
   output logic [2:0]          rsp_status,
   output logic [HEIGHT_W-1:0] rsp_entry_height,
   output logic                rsp_last,
   output logic [CNT_W-1:0]    rsp_ready_count,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [31:0]         csr_wdata
);

   localparam int AW = $clog2(TABLE_DEPTH);
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int SW = ((CW > CNT_W) ? CW : CNT_W) + 1;
   localparam logic [CNT_W-1:0] LIM_MAX = CNT_W'(MAX_BATCH);
   localparam logic [CW-1:0]    FULL    = CW'(TABLE_DEPTH);

   // configuration
   logic [31:0]      deadline_ff, backoff_ff;
   logic [CNT_W-1:0] batch_ff;
   logic [4:0]       credit_ff;

   // item and control
   state_type           state_ff, state_in;
   logic [CW-1:0]       idx_ff, idx_in, used_ff, used_in, pos_ff, pos_in;
   logic [CW-1:0]       outst_ff, outst_in;
   logic                eval_ff, eval_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in, rt_ff, rt_in, lim_ff, lim_in;
   logic [31:0]         last_nack_ff, last_nack_in;
   logic [HEIGHT_W-1:0] h_ff;
   logic [KEY_W-1:0]    key_ff, id_ff;
   logic [TICK_W-1:0]   now_ff;
   logic [7:0]          peers_ff;
   logic                lip_ff;
   logic [12:0]         cp_ff;
   logic [19:0]         cap_ff;

   // result hold and output beat
   logic                pend_vld_ff, pend_vld_in;
   status_type          pend_stat_ff, pend_stat_in;
   logic [HEIGHT_W-1:0] pend_h_ff, pend_h_in;
   logic                out_vld_ff, out_vld_in, out_last_ff, out_last_in;
   status_type          out_stat_ff, out_stat_in;
   logic [HEIGHT_W-1:0] out_h_ff, out_h_in;
   logic [CNT_W-1:0]    out_rc_ff;

   // memory port
   logic          wr_en, flush, push;
   logic [AW-1:0] wr_addr, rd_addr;
   entry_type     wr_data, rd;
   status_type    push_stat;
   logic [HEIGHT_W-1:0] push_h;

   logic [TICK_W-1:0] age;
   logic              in_range, id_hit;
   logic [SW-1:0]     shift_src;

   dtr_entry_ram #(.DEPTH(TABLE_DEPTH)) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd)
   );

   assign age       = now_ff - rd.req_time;
   assign in_range  = idx_ff < used_ff;
   assign id_hit    = rd.requested && (rd.req_id == id_ff);
   assign shift_src = SW'(idx_ff) + SW'(cnt_ff);

   // configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         deadline_ff <= 32'd1000;
         batch_ff    <= 7'd32;
         backoff_ff  <= 32'd100;
         credit_ff   <= 5'd4;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_index))
            CSR_DEADLINE: deadline_ff <= csr_wdata;
            CSR_BATCH:    batch_ff    <= csr_wdata[CNT_W-1:0];
            CSR_BACKOFF:  backoff_ff  <= csr_wdata;
            CSR_CREDIT:   credit_ff   <= csr_wdata[4:0];
            default: ;
         endcase
      end
   end

   // item capture and credit product, one multiply per stage
   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         h_ff     <= req_block_height;
         key_ff   <= req_match_key;
         id_ff    <= req_request_id;
         now_ff   <= req_now_ticks;
         peers_ff <= req_active_peers;
         lip_ff   <= req_last_in_packet;
      end
      cp_ff  <= 13'(credit_ff) * 13'(peers_ff);
      cap_ff <= 20'(cp_ff) * 20'(lim_ff);
   end

   // sequencer
   always_comb begin
      state_in     = state_ff;
      idx_in       = idx_ff;
      eval_in      = eval_ff;
      used_in      = used_ff;
      pos_in       = pos_ff;
      outst_in     = outst_ff;
      cnt_in       = cnt_ff;
      rt_in        = rt_ff;
      lim_in       = lim_ff;
      last_nack_in = last_nack_ff;
      wr_en        = 1'b0;
      wr_addr      = idx_ff[AW-1:0];
      wr_data      = rd;
      rd_addr      = idx_ff[AW-1:0];
      push         = 1'b0;
      push_stat    = STAT_EMPTY;
      push_h       = '0;
      flush        = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            if (start) begin
               idx_in  = '0;
               eval_in = 1'b0;
               cnt_in  = '0;
               outst_in = '0;
               lim_in  = (batch_ff == '0) ? CNT_W'(1) :
                         ((batch_ff > LIM_MAX) ? LIM_MAX : batch_ff);
               case (req_func)
                  FUNC_ADD:      state_in = ST_A_SCAN;
                  FUNC_ACCEPT:   state_in = ST_C_ID;
                  FUNC_BATCH:    state_in = ST_B_CHK;
                  FUNC_NACK: begin
                     last_nack_in = req_now_ticks;
                     state_in     = ST_N_SCAN;
                  end
                  FUNC_WITHDRAW: state_in = ST_W_CNT;
                  default:       state_in = ST_IDLE;
               endcase
            end
         end

         // add: find insert point
         ST_A_SCAN: begin
            if (!eval_ff) begin
               if (in_range) eval_in = 1'b1;
               else begin
                  pos_in   = idx_ff;
                  state_in = ST_A_DEC;
               end
            end else begin
               eval_in = 1'b0;
               if (rd.height < h_ff) idx_in = idx_ff + 1'b1;
               else if (rd.height == h_ff) begin
                  push      = 1'b1;
                  push_stat = STAT_DUP;
                  push_h    = h_ff;
                  state_in  = ST_DONE;
               end else begin
                  pos_in   = idx_ff;
                  state_in = ST_A_DEC;
               end
            end
         end

         ST_A_DEC: begin
            if (used_ff == FULL) begin
               push      = 1'b1;
               push_stat = STAT_FULL;
               state_in  = ST_DONE;
            end else begin
               idx_in   = used_ff;
               eval_in  = 1'b0;
               state_in = ST_A_SHIFT;
            end
         end

         // add: move entries up from the top down to the insert point
         ST_A_SHIFT: begin
            rd_addr = AW'(idx_ff - 1'b1);
            if (!eval_ff) begin
               if (idx_ff > pos_ff) eval_in = 1'b1;
               else state_in = ST_A_PUT;
            end else begin
               wr_en   = 1'b1;
               idx_in  = idx_ff - 1'b1;
               eval_in = 1'b0;
            end
         end

         ST_A_PUT: begin
            wr_en            = 1'b1;
            wr_addr          = pos_ff[AW-1:0];
            wr_data.height   = h_ff;
            wr_data.key      = key_ff;
            wr_data.req_id   = '0;
            wr_data.req_time = '0;
            wr_data.ready    = 1'b0;
            wr_data.matched  = 1'b0;
            wr_data.requested = 1'b0;
            used_in          = used_ff + 1'b1;
            push             = 1'b1;
            push_stat        = STAT_ADDED;
            push_h           = h_ff;
            state_in         = ST_DONE;
         end

         // accept: match by id and key
         ST_C_ID: begin
            if (!eval_ff) begin
               if (in_range) eval_in = 1'b1;
               else begin
                  idx_in   = '0;
                  state_in = ST_C_KEY;
               end
            end else begin
               eval_in = 1'b0;
               if (id_hit && !rd.matched && rd.key == key_ff) begin
                  wr_en           = 1'b1;
                  wr_data.matched = 1'b1;
                  wr_data.ready   = 1'b1;
                  push            = 1'b1;
                  push_stat       = rd.ready ? STAT_DUP : STAT_ACCEPTED;
                  push_h          = rd.height;
                  if (!rd.ready) rt_in = rt_ff + 1'b1;
                  state_in        = ST_C_END;
               end else idx_in = idx_ff + 1'b1;
            end
         end

         // accept: fall back to key alone
         ST_C_KEY: begin
            if (!eval_ff) begin
               if (in_range) eval_in = 1'b1;
               else begin
                  push      = 1'b1;
                  push_stat = STAT_NOT_REQ;
                  state_in  = ST_C_END;
               end
            end else begin
               eval_in = 1'b0;
               if (rd.key == key_ff) begin
                  wr_en         = 1'b1;
                  wr_data.ready = 1'b1;
                  push          = 1'b1;
                  push_stat     = rd.ready ? STAT_DUP : STAT_ACCEPTED;
                  push_h        = rd.height;
                  if (!rd.ready) rt_in = rt_ff + 1'b1;
                  state_in      = ST_C_END;
               end else idx_in = idx_ff + 1'b1;
            end
         end

         ST_C_END: begin
            idx_in   = '0;
            eval_in  = 1'b0;
            state_in = lip_ff ? ST_C_CLR : ST_DONE;
         end

         // end of packet: drop unmatched requests of this id, clear match marks
         ST_C_CLR: begin
            if (!eval_ff) begin
               if (in_range) eval_in = 1'b1;
               else state_in = ST_DONE;
            end else begin
               wr_en = 1'b1;
               if (id_hit && !rd.matched) begin
                  wr_data.requested = 1'b0;
                  wr_data.req_id    = '0;
                  wr_data.req_time  = '0;
               end
               wr_data.matched = 1'b0;
               idx_in  = idx_ff + 1'b1;
               eval_in = 1'b0;
            end
         end

         // batch: back-off check
         ST_B_CHK: begin
            if ((now_ff - last_nack_ff) < backoff_ff) begin
               push      = 1'b1;
               push_stat = STAT_EMPTY;
               state_in  = ST_DONE;
            end else state_in = ST_B_STALE;
         end

         // batch: renew stale entries
         ST_B_STALE: begin
            if (!eval_ff) begin
               if (in_range) eval_in = 1'b1;
               else begin
                  idx_in   = '0;
                  state_in = ST_B_CNT;
               end
            end else begin
               eval_in = 1'b0;
               idx_in  = idx_ff + 1'b1;
               if (!rd.ready && age >= deadline_ff) begin
                  wr_en             = 1'b1;
                  wr_data.req_time  = now_ff;
                  wr_data.req_id    = id_ff;
                  wr_data.requested = 1'b1;
                  push              = 1'b1;
                  push_stat         = STAT_LINE;
                  push_h            = rd.height;
                  cnt_in            = cnt_ff + 1'b1;
                  if (cnt_ff + 1'b1 >= lim_ff) state_in = ST_B_FIN;
               end
            end
         end

         // batch: count outstanding requests in the requested prefix
         ST_B_CNT: begin
            if (!eval_ff) begin
               if (in_range) eval_in = 1'b1;
               else state_in = ST_B_CMP;
            end else begin
               eval_in = 1'b0;
               if (!rd.requested) state_in = ST_B_CMP;
               else begin
                  if (!rd.ready && age < deadline_ff) outst_in = outst_ff + 1'b1;
                  idx_in = idx_ff + 1'b1;
               end
            end
         end

         ST_B_CMP: begin
            idx_in   = '0;
            eval_in  = 1'b0;
            state_in = (20'(outst_ff) < cap_ff) ? ST_B_NEW : ST_B_FIN;
         end

         // batch: name unrequested entries
         ST_B_NEW: begin
            if (!eval_ff) begin
               if (in_range) eval_in = 1'b1;
               else state_in = ST_B_FIN;
            end else begin
               eval_in = 1'b0;
               idx_in  = idx_ff + 1'b1;
               if (!rd.requested) begin
                  wr_en             = 1'b1;
                  wr_data.req_time  = now_ff;
                  wr_data.req_id    = id_ff;
                  wr_data.requested = 1'b1;
                  push              = 1'b1;
                  push_stat         = STAT_LINE;
                  push_h            = rd.height;
                  cnt_in            = cnt_ff + 1'b1;
                  if (cnt_ff + 1'b1 >= lim_ff) state_in = ST_B_FIN;
               end
            end
         end

         ST_B_FIN: begin
            if (cnt_ff == '0) begin
               push      = 1'b1;
               push_stat = STAT_EMPTY;
            end
            state_in = ST_DONE;
         end

         // nack: age out requests of this id
         ST_N_SCAN: begin
            if (!eval_ff) begin
               if (in_range) eval_in = 1'b1;
               else state_in = ST_IDLE;
            end else begin
               if (id_hit) begin
                  wr_en            = 1'b1;
                  wr_data.req_time = rd.req_time - deadline_ff;
               end
               idx_in  = idx_ff + 1'b1;
               eval_in = 1'b0;
            end
         end

         // withdraw: measure the ready run from the bottom
         ST_W_CNT: begin
            if (!eval_ff) begin
               if (in_range && cnt_ff < MAX_RESULTS) eval_in = 1'b1;
               else state_in = ST_W_UPD;
            end else begin
               eval_in = 1'b0;
               if (rd.ready) begin
                  cnt_in = cnt_ff + 1'b1;
                  idx_in = idx_ff + 1'b1;
               end else state_in = ST_W_UPD;
            end
         end

         ST_W_UPD: begin
            rt_in   = (rt_ff > cnt_ff) ? (rt_ff - cnt_ff) : '0;
            idx_in  = '0;
            eval_in = 1'b0;
            if (cnt_ff == '0) begin
               push      = 1'b1;
               push_stat = STAT_EMPTY;
               state_in  = ST_DONE;
            end else state_in = ST_W_OUT;
         end

         ST_W_OUT: begin
            if (!eval_ff) begin
               if (SW'(idx_ff) < SW'(cnt_ff)) eval_in = 1'b1;
               else begin
                  idx_in   = '0;
                  state_in = ST_W_SHIFT;
               end
            end else begin
               push      = 1'b1;
               push_stat = STAT_WITHDRAWN;
               push_h    = rd.height;
               idx_in    = idx_ff + 1'b1;
               eval_in   = 1'b0;
            end
         end

         // withdraw: close the gap
         ST_W_SHIFT: begin
            rd_addr = shift_src[AW-1:0];
            if (!eval_ff) begin
               if (shift_src < SW'(used_ff)) eval_in = 1'b1;
               else begin
                  used_in  = used_ff - CW'(cnt_ff);
                  state_in = ST_DONE;
               end
            end else begin
               wr_en   = 1'b1;
               idx_in  = idx_ff + 1'b1;
               eval_in = 1'b0;
            end
         end

         ST_DONE: begin
            flush    = 1'b1;
            state_in = ST_IDLE;
         end

         default: state_in = ST_IDLE;
      endcase
   end

   // result hold: a beat is released once the next one is known or at the end
   always_comb begin
      pend_vld_in  = pend_vld_ff;
      pend_stat_in = pend_stat_ff;
      pend_h_in    = pend_h_ff;
      out_vld_in   = 1'b0;
      out_last_in  = 1'b0;
      out_stat_in  = pend_stat_ff;
      out_h_in     = pend_h_ff;
      if (push) begin
         out_vld_in   = pend_vld_ff;
         pend_vld_in  = 1'b1;
         pend_stat_in = push_stat;
         pend_h_in    = push_h;
      end else if (flush && pend_vld_ff) begin
         out_vld_in  = 1'b1;
         out_last_in = 1'b1;
         pend_vld_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         eval_ff      <= 1'b0;
         used_ff      <= '0;
         rt_ff        <= '0;
         last_nack_ff <= '0;
         pend_vld_ff  <= 1'b0;
         out_vld_ff   <= 1'b0;
      end else begin
         state_ff     <= state_in;
         eval_ff      <= eval_in;
         used_ff      <= used_in;
         rt_ff        <= rt_in;
         last_nack_ff <= last_nack_in;
         pend_vld_ff  <= pend_vld_in;
         out_vld_ff   <= out_vld_in;
      end
   end

   // datapath registers
   always_ff @(posedge clock) begin
      idx_ff       <= idx_in;
      pos_ff       <= pos_in;
      outst_ff     <= outst_in;
      cnt_ff       <= cnt_in;
      lim_ff       <= lim_in;
      pend_stat_ff <= pend_stat_in;
      pend_h_ff    <= pend_h_in;
      out_stat_ff  <= out_stat_in;
      out_h_ff     <= out_h_in;
      out_last_ff  <= out_last_in;
      out_rc_ff    <= rt_ff;
   end

   assign busy             = (state_ff != ST_IDLE);
   assign rsp_strobe       = out_vld_ff;
   assign rsp_status       = out_stat_ff;
   assign rsp_entry_height = out_h_ff;
   assign rsp_last         = out_last_ff;
   assign rsp_ready_count  = out_rc_ff;

   // checks
   a_used_bound: assert property (@(posedge clock) disable iff (reset)
      used_ff <= FULL)
      else $error("fill count beyond table depth");

   a_idle_no_pend: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_IDLE |-> !pend_vld_ff)
      else $error("held result left behind at idle");

   a_last_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_last |=> !rsp_strobe)
      else $error("beat right after final beat");

endmodule

FILE: verif/tb.sv
// Self-checking testbench for the download request tracker.
module tb;
   import dtr_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DEPTH       = 64;
   localparam int SETTLE_CYC  = 500;
   localparam int CYCLE_LIMIT = 3000000;

   // One input beat
   typedef struct {
      logic [2:0]          func;
      logic [HEIGHT_W-1:0] h;
      logic [KEY_W-1:0]    key;
      logic [KEY_W-1:0]    id;
      logic [TICK_W-1:0]   now;
      logic [7:0]          peers;
      logic                lastp;
   } tracker_op_type;

   // One result beat
   typedef struct {
      status_type          status;
      logic [HEIGHT_W-1:0] h;
      logic                last;
      logic [CNT_W-1:0]    rc;
   } tracker_res_type;

   // Directed row: an input with an optional typed-in result
   typedef struct {
      tracker_op_type      op;
      bit                  typed;
      status_type          status;
      logic [HEIGHT_W-1:0] h;
   } directed_row_type;

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                start = 1'b0;
   logic                busy;
   logic [2:0]          req_func = '0;
   logic [HEIGHT_W-1:0] req_block_height = '0;
   logic [KEY_W-1:0]    req_match_key = '0;
   logic [KEY_W-1:0]    req_request_id = '0;
   logic [TICK_W-1:0]   req_now_ticks = '0;
   logic [7:0]          req_active_peers = '0;
   logic                req_last_in_packet = 1'b0;
   logic                rsp_strobe;
   logic [2:0]          rsp_status;
   logic [HEIGHT_W-1:0] rsp_entry_height;
   logic                rsp_last;
   logic [CNT_W-1:0]    rsp_ready_count;
   logic                csr_we = 1'b0;
   logic [1:0]          csr_index = '0;
   logic [31:0]         csr_wdata = '0;

   download_request_tracker dut (.*);

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Mirror of the tracker state
   logic [HEIGHT_W-1:0] tbl_h     [DEPTH];
   logic [KEY_W-1:0]    tbl_key   [DEPTH];
   logic [KEY_W-1:0]    tbl_id    [DEPTH];
   logic [TICK_W-1:0]   tbl_time  [DEPTH];
   bit                  tbl_ready [DEPTH];
   bit                  tbl_match [DEPTH];
   bit                  tbl_reqd  [DEPTH];
   int                  fill = 0;
   logic [TICK_W-1:0]   nack_time = '0;
   logic [CNT_W-1:0]    ready_total = '0;
   logic [HEIGHT_W-1:0] top_withdrawn = '0;
   logic [31:0]         cfg_deadline = 32'd1000;
   logic [6:0]          cfg_batch = 7'd32;
   logic [31:0]         cfg_backoff = 32'd100;
   logic [4:0]          cfg_credit = 5'd4;

   tracker_res_type expected_q[$];
   int errors = 0;
   int items_sent = 0;
   int results_seen = 0;
   int cycles = 0;
   int burst_left = 0;
   logic [TICK_W-1:0]   now_t = 32'd2000;
   logic [HEIGHT_W-1:0] hbase = '0;

   function automatic logic [63:0] rand64();
      return {$urandom, $urandom};
   endfunction

   function automatic void move_slot(int d, int s);
      tbl_h[d] = tbl_h[s];
      tbl_key[d] = tbl_key[s];
      tbl_id[d] = tbl_id[s];
      tbl_time[d] = tbl_time[s];
      tbl_ready[d] = tbl_ready[s];
      tbl_match[d] = tbl_match[s];
      tbl_reqd[d] = tbl_reqd[s];
   endfunction

   function automatic void name_line(int i, logic [63:0] id, logic [31:0] now,
                                     ref tracker_res_type res[$]);
      tracker_res_type r;
      tbl_time[i] = now;
      tbl_id[i] = id;
      tbl_reqd[i] = 1'b1;
      r.status = STAT_LINE;
      r.h = tbl_h[i];
      res = {res, r};
   endfunction

   // Work out the results of one accepted beat and update the mirror
   function automatic void predict_tracker_op(tracker_op_type op);
      tracker_res_type res[$];
      tracker_res_type r;
      int pos, i, hit, lim;
      logic [31:0] outst;
      r.h = '0;
      r.last = 1'b0;
      r.rc = '0;
      case (op.func)
         FUNC_ADD: begin
            pos = 0;
            while (pos < fill && tbl_h[pos] < op.h) pos++;
            if (pos < fill && tbl_h[pos] == op.h) begin
               r.status = STAT_DUP; r.h = op.h;
            end else if (fill >= DEPTH) begin
               r.status = STAT_FULL; r.h = '0;
            end else begin
               for (i = fill; i > pos; i--) move_slot(i, i - 1);
               tbl_h[pos] = op.h;
               tbl_key[pos] = op.key;
               tbl_id[pos] = '0;
               tbl_time[pos] = '0;
               tbl_ready[pos] = 1'b0;
               tbl_match[pos] = 1'b0;
               tbl_reqd[pos] = 1'b0;
               fill++;
               r.status = STAT_ADDED; r.h = op.h;
            end
            res = {res, r};
         end
         FUNC_ACCEPT: begin
            hit = fill;
            for (i = 0; i < fill; i++)
               if (tbl_reqd[i] && tbl_id[i] == op.id && !tbl_match[i] &&
                   tbl_key[i] == op.key) begin
                  tbl_match[i] = 1'b1;
                  hit = i;
                  break;
               end
            // fall back to the first entry with this key
            if (hit == fill)
               for (i = 0; i < fill; i++)
                  if (tbl_key[i] == op.key) begin
                     hit = i;
                     break;
                  end
            if (hit == fill) begin
               r.status = STAT_NOT_REQ; r.h = '0;
            end else if (!tbl_ready[hit]) begin
               tbl_ready[hit] = 1'b1;
               ready_total++;
               r.status = STAT_ACCEPTED; r.h = tbl_h[hit];
            end else begin
               r.status = STAT_DUP; r.h = tbl_h[hit];
            end
            res = {res, r};
            // end of packet drops unmatched requests of this id
            if (op.lastp) begin
               for (i = 0; i < fill; i++)
                  if (tbl_reqd[i] && tbl_id[i] == op.id && !tbl_match[i]) begin
                     tbl_reqd[i] = 1'b0;
                     tbl_id[i] = '0;
                     tbl_time[i] = '0;
                  end
               for (i = 0; i < DEPTH; i++) tbl_match[i] = 1'b0;
            end
         end
         FUNC_BATCH: begin
            lim = int'(cfg_batch);
            if (lim < 1) lim = 1;
            if (lim > 64) lim = 64;
            if (32'(op.now - nack_time) >= cfg_backoff) begin
               // renew stale entries first
               for (i = 0; i < fill; i++) begin
                  if (tbl_ready[i] || 32'(op.now - tbl_time[i]) < cfg_deadline) continue;
                  name_line(i, op.id, op.now, res);
                  if (res.size() >= lim) break;
               end
               if (res.size() < lim) begin
                  outst = 0;
                  for (i = 0; i < fill; i++) begin
                     if (!tbl_reqd[i]) break;
                     if (!tbl_ready[i] && 32'(op.now - tbl_time[i]) < cfg_deadline)
                        outst++;
                  end
                  if (64'(outst) < 64'(cfg_credit) * 64'(op.peers) * 64'(lim))
                     for (i = 0; i < fill; i++) begin
                        if (tbl_reqd[i]) continue;
                        name_line(i, op.id, op.now, res);
                        if (res.size() >= lim) break;
                     end
               end
            end
            if (res.size() == 0) begin
               r.status = STAT_EMPTY; r.h = '0;
               res = {res, r};
            end
         end
         FUNC_NACK: begin
            for (i = 0; i < fill; i++)
               if (tbl_reqd[i] && tbl_id[i] == op.id)
                  tbl_time[i] = tbl_time[i] - cfg_deadline;
            nack_time = op.now;
         end
         FUNC_WITHDRAW: begin
            while (fill > 0 && tbl_ready[0] && res.size() < 64) begin
               if (tbl_h[0] > top_withdrawn) top_withdrawn = tbl_h[0];
               r.status = STAT_WITHDRAWN; r.h = tbl_h[0];
               res = {res, r};
               for (i = 1; i < fill; i++) move_slot(i - 1, i);
               fill--;
               tbl_ready[fill] = 1'b0;
               tbl_match[fill] = 1'b0;
               tbl_reqd[fill] = 1'b0;
               if (ready_total > 0) ready_total--;
            end
            if (res.size() == 0) begin
               r.status = STAT_EMPTY; r.h = '0;
               res = {res, r};
            end
         end
         default: ;
      endcase
      foreach (res[k]) begin
         res[k].rc = ready_total;
         res[k].last = (k == res.size() - 1);
         expected_q = {expected_q, res[k]};
      end
   endfunction

   // Drive one beat in bursts with random gaps; returns on the accepting edge
   task automatic send(tracker_op_type op);
      int gap;
      gap = 0;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 12);
         if ($urandom_range(0, 3) != 0) gap = $urandom_range(1, 20);
      end
      burst_left--;
      if (gap > 0) begin
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      start <= 1'b1;
      req_func <= op.func;
      req_block_height <= op.h;
      req_match_key <= op.key;
      req_request_id <= op.id;
      req_now_ticks <= op.now;
      req_active_peers <= op.peers;
      req_last_in_packet <= op.lastp;
      do @(posedge clock); while (busy);
      predict_tracker_op(op);
      if (op.func <= FUNC_WITHDRAW) items_sent++;
   endtask

   // Wait until every result is in and the block has gone quiet
   task automatic settle();
      start <= 1'b0;
      do @(posedge clock); while (expected_q.size() != 0 || busy);
      repeat (SETTLE_CYC) @(posedge clock);
   endtask

   task automatic csr_put(csr_index_type idx, logic [31:0] val);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(posedge clock);
      case (idx)
         CSR_DEADLINE: cfg_deadline = val;
         CSR_BATCH:    cfg_batch = val[6:0];
         CSR_BACKOFF:  cfg_backoff = val;
         CSR_CREDIT:   cfg_credit = val[4:0];
      endcase
   endtask

   task automatic configure(logic [31:0] dl, logic [31:0] bl, logic [31:0] bo,
                            logic [31:0] cr);
      csr_put(CSR_DEADLINE, dl);
      csr_put(CSR_BATCH, bl);
      csr_put(CSR_BACKOFF, bo);
      csr_put(CSR_CREDIT, cr);
      csr_we <= 1'b0;
      @(posedge clock);
   endtask

   // Random beat of the given operation, every field filled
   function automatic tracker_op_type mk(logic [2:0] f);
      tracker_op_type op;
      op.func = f;
      op.h = HEIGHT_W'(rand64());
      op.key = rand64();
      op.id = rand64();
      op.now = $urandom;
      op.peers = 8'($urandom);
      op.lastp = 1'($urandom);
      return op;
   endfunction

   function automatic logic [HEIGHT_W-1:0] next_height();
      hbase = hbase + HEIGHT_W'($urandom_range(1, 3));
      if ($urandom_range(0, 9) == 0) return HEIGHT_W'(rand64());
      return hbase;
   endfunction

   function automatic logic [63:0] pick_key();
      if ($urandom_range(0, 9) < 3) return 64'($urandom_range(0, 7));
      return rand64();
   endfunction

   function automatic directed_row_type row(logic [2:0] f, logic [39:0] h, logic [63:0] key,
                                            logic [63:0] id, logic [31:0] now,
                                            logic [7:0] peers, logic lastp, bit typed,
                                            status_type st, logic [39:0] eh);
      directed_row_type d;
      d.op.func = f; d.op.h = h; d.op.key = key; d.op.id = id;
      d.op.now = now; d.op.peers = peers; d.op.lastp = lastp;
      d.typed = typed; d.status = st; d.h = eh;
      return d;
   endfunction

   // Add a few entries, request them, answer the packet, maybe nack and withdraw
   task automatic run_round();
      tracker_op_type op;
      logic [63:0] id;
      logic [63:0] keys[$];
      int k, i;
      k = $urandom_range(1, 6);
      for (i = 0; i < k; i++) begin
         op = mk(FUNC_ADD);
         op.h = next_height();
         op.key = pick_key();
         send(op);
      end
      now_t = now_t + $urandom_range(0, 400);
      id = rand64();
      op = mk(FUNC_BATCH);
      op.id = id;
      op.now = now_t;
      if ($urandom_range(0, 4) != 0) op.peers = 8'($urandom_range(1, 4));
      send(op);
      for (i = 0; i < fill; i++)
         if (tbl_reqd[i] && tbl_id[i] == id && $urandom_range(0, 4) != 0)
            keys = {keys, tbl_key[i]};
      foreach (keys[j]) begin
         op = mk(FUNC_ACCEPT);
         op.key = ($urandom_range(0, 9) == 0) ? rand64() : keys[j];
         op.id = id;
         op.lastp = (j == keys.size() - 1);
         send(op);
      end
      if (keys.size() == 0 && $urandom_range(0, 1)) begin
         op = mk(FUNC_ACCEPT);
         op.id = id;
         op.lastp = 1'b1;
         send(op);
      end
      if ($urandom_range(0, 3) == 0) begin
         op = mk(FUNC_NACK);
         op.id = id;
         op.now = now_t;
         send(op);
      end
      if ($urandom_range(0, 1)) send(mk(FUNC_WITHDRAW));
   endtask

   // Single random beat, any code, sometimes aimed at live entries
   task automatic run_noise();
      tracker_op_type op;
      op = mk(3'($urandom_range(0, 7)));
      if ((op.func == FUNC_BATCH || op.func == FUNC_NACK) && $urandom_range(0, 1)) begin
         now_t = now_t + $urandom_range(0, 300);
         op.now = now_t;
      end
      if (op.func == FUNC_ACCEPT && fill > 0 && $urandom_range(0, 1))
         op.key = tbl_key[$urandom_range(0, fill - 1)];
      if (op.func == FUNC_ADD && $urandom_range(0, 1)) op.h = next_height();
      send(op);
   endtask

   // Result checker
   always @(posedge clock) begin
      tracker_res_type e;
      if (!reset && rsp_strobe) begin
         results_seen++;
         if (expected_q.size() == 0) begin
            errors++;
            $display("%0t: unexpected beat status=%0d height=%0h", $realtime,
                     rsp_status, rsp_entry_height);
         end else begin
            e = expected_q.pop_front();
            if (rsp_status !== e.status || rsp_entry_height !== e.h ||
                rsp_last !== e.last || rsp_ready_count !== e.rc) begin
               errors++;
               $display("%0t: mismatch expected status=%0d height=%0h last=%0b rc=%0d",
                        $realtime, e.status, e.h, e.last, e.rc);
               $display("%0t:          actual   status=%0d height=%0h last=%0b rc=%0d",
                        $realtime, rsp_status, rsp_entry_height, rsp_last,
                        rsp_ready_count);
            end
         end
      end
   end

   // Watchdog
   always @(posedge clock) begin
      cycles++;
      if (cycles > CYCLE_LIMIT) begin
         $display("Some tests failed");
         $finish;
      end
   end

   initial begin
      directed_row_type rows[$];
      tracker_op_type op;
      int p, i, goal;
      rows = {rows, row(FUNC_WITHDRAW, 0, 0, 0, 0, 0, 0, 1, STAT_EMPTY, 0)};
      rows = {rows, row(FUNC_BATCH, 0, 0, 1, 0, 1, 0, 1, STAT_EMPTY, 0)};
      rows = {rows, row(FUNC_ADD, 0, 1, 0, 0, 0, 0, 1, STAT_ADDED, 0)};
      rows = {rows, row(FUNC_ADD, '1, 2, 0, 0, 0, 0, 1, STAT_ADDED, '1)};
      rows = {rows, row(FUNC_ADD, 0, 9, 0, 0, 0, 0, 1, STAT_DUP, 0)};
      rows = {rows, row(FUNC_ACCEPT, 0, 5, 0, 0, 0, 0, 1, STAT_NOT_REQ, 0)};
      rows = {rows, row(FUNC_BATCH, 0, 0, 7, 5000, 1, 0, 0, STAT_EMPTY, 0)};
      rows = {rows, row(FUNC_ACCEPT, 0, 2, 7, 0, 0, 0, 0, STAT_EMPTY, 0)};
      rows = {rows, row(FUNC_ACCEPT, 0, 2, 7, 0, 0, 0, 0, STAT_EMPTY, 0)};
      // key match by fallback on a foreign id, ending the packet
      rows = {rows, row(FUNC_ACCEPT, 0, 1, 9, 0, 0, 1, 0, STAT_EMPTY, 0)};
      rows = {rows, row(FUNC_WITHDRAW, 0, 0, 0, 0, 0, 0, 0, STAT_EMPTY, 0)};
      rows = {rows, row(FUNC_ADD, 10, 3, 0, 0, 0, 0, 1, STAT_ADDED, 10)};
      rows = {rows, row(FUNC_BATCH, 0, 0, 8, 6000, 255, 0, 0, STAT_EMPTY, 0)};
      rows = {rows, row(FUNC_NACK, 0, 0, 8, 6000, 0, 0, 0, STAT_EMPTY, 0)};
      // inside the back-off window
      rows = {rows, row(FUNC_BATCH, 0, 0, 8, 6050, 1, 0, 1, STAT_EMPTY, 0)};
      rows = {rows, row(FUNC_ADD, 12, 4, 0, 0, 0, 0, 1, STAT_ADDED, 12)};
      // no credit with zero peers, stale renewal only
      rows = {rows, row(FUNC_BATCH, 0, 0, '1, 7200, 0, 0, 0, STAT_EMPTY, 0)};
      rows = {rows, row(FUNC_ACCEPT, 0, 3, '1, 0, 0, 1, 0, STAT_EMPTY, 0)};
      rows = {rows, row(3'd5, '1, '1, '1, '1, '1, 1, 0, STAT_EMPTY, 0)};
      rows = {rows, row(3'd7, 0, 0, 0, 0, 0, 0, 0, STAT_EMPTY, 0)};
      rows = {rows, row(FUNC_WITHDRAW, 0, 0, 0, 0, 0, 0, 0, STAT_EMPTY, 0)};

      repeat (2) @(posedge clock);
      reset <= 1'b0;
      foreach (rows[r]) begin
         send(rows[r].op);
         if (rows[r].typed) begin
            expected_q[$].status = rows[r].status;
            expected_q[$].h = rows[r].h;
         end
      end

      for (p = 1; p <= 5; p++) begin
         settle();
         case (p)
            1: configure(32'd1, 32'd1, 32'd0, 32'd1);
            2: configure('1, 32'd64, '1, 32'd16);
            3: configure(32'd200, 32'd0, 32'd0, 32'd31);
            4: configure(32'd500, 32'd127, 32'd50, 32'd2);
            default: configure($urandom_range(100, 2000), $urandom_range(1, 64),
                               $urandom_range(0, 200), $urandom_range(1, 16));
         endcase
         // overfill the table once
         if (p == 4)
            for (i = 0; i < DEPTH + 2; i++) begin
               op = mk(FUNC_ADD);
               op.h = next_height();
               send(op);
            end
         goal = items_sent + 68;
         while (items_sent < goal) begin
            if ($urandom_range(0, 9) < 7) run_round();
            else run_noise();
         end
      end

      settle();
      $display("Covered %0d input beats and %0d result beats over five register settings.",
               items_sent, results_seen);
      if (errors == 0) $display("All tests passed");
      else $display("Some tests failed");
      $finish;
   end

endmodule
